### rtl/pmsp_pkg.sv
// ----------------------------------------------------------------------------
// pmsp_pkg
// Shared types and constants for the permission mode string parser.
// ----------------------------------------------------------------------------
package pmsp_pkg;

  // Parse phase of the string being read
  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_OCTAL   = 3'd1,
    PH_WHO     = 3'd2,
    PH_PERM    = 3'd3,
    PH_ERR_OCT = 3'd4,
    PH_ERR_SYM = 3'd5
  } phase_e;

  // Pending operator of a permission group
  typedef enum logic [1:0] {
    OP_SET = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2
  } op_e;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_OCT = 2'd1;
  localparam logic [1:0] ST_BAD_SYM = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_CREATION_MASK = 2'd0;
  localparam logic [1:0] CFG_SUPERUSER     = 2'd1;

  // Mode bit groups
  localparam logic [11:0] ALL_BITS  = 12'o7777;
  localparam logic [11:0] OWN_BITS  = 12'o5700;
  localparam logic [11:0] GRP_BITS  = 12'o3070;
  localparam logic [11:0] OTH_BITS  = 12'o1007;
  localparam logic [11:0] RD_BITS   = 12'o0444;
  localparam logic [11:0] WR_BITS   = 12'o0222;
  localparam logic [11:0] EX_BITS   = 12'o0111;
  localparam logic [11:0] SID_BITS  = 12'o6000;
  localparam logic [11:0] STICKY    = 12'o1000;
  localparam logic [11:0] CMASK_RST = 12'o0022;

  // Characters of the mode grammar
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Input beat
  typedef struct packed {
    logic [7:0]  character;
    logic [11:0] base_mode;
    logic        last;
  } in_t;

  // Result beat
  typedef struct packed {
    logic [11:0] new_mode;
    logic [1:0]  status;
    logic        sticky_warning;
  } out_t;

  // Parser state carried from one character to the next
  typedef struct packed {
    phase_e      phase;
    logic [11:0] who_mask;
    op_e         pending_op;
    logic [11:0] perm_mask;
    logic [11:0] working_mode;
    logic        warning_given;
  } state_t;

endpackage

### rtl/pmsp_step.sv
// ----------------------------------------------------------------------------
// pmsp_step
// Next-state and result logic for one character of the mode string.
// ----------------------------------------------------------------------------
module pmsp_step (
  input  pmsp_pkg::state_t state_i,
  input  pmsp_pkg::in_t    beat_i,
  input  logic [11:0]      creation_mask_i,
  input  logic             superuser_i,
  output pmsp_pkg::state_t state_o,
  output logic             push_o,
  output pmsp_pkg::out_t   result_o
);

  // Apply a permission group to a mode
  function automatic logic [11:0] apply_group(logic [11:0] mode, logic [11:0] who,
                                               logic [11:0] perm, pmsp_pkg::op_e op);
    logic [11:0] sel;
    logic [11:0] res;
    sel = who & perm;
    case (op)
      pmsp_pkg::OP_SUB: res = mode & ~sel;
      pmsp_pkg::OP_ADD: res = mode | sel;
      default:          res = (mode & ~who) | sel;
    endcase
    return res & pmsp_pkg::ALL_BITS;
  endfunction

  // Copy one rwx triple into all three classes
  function automatic logic [11:0] spread(logic [2:0] rwx);
    return {3'b000, rwx, rwx, rwx};
  endfunction

  logic          is_digit;
  logic          is_op;
  pmsp_pkg::op_e op_code;
  logic [2:0]    digit;
  logic          do_sym;
  logic          ok;
  logic [11:0]   res_mode;
  logic [1:0]    res_status;
  logic          warn;
  pmsp_pkg::state_t a_st;
  pmsp_pkg::state_t b_st;

  assign is_digit = (beat_i.character >= pmsp_pkg::CH_0) &&
                    (beat_i.character <= pmsp_pkg::CH_7);
  assign digit    = beat_i.character[2:0];

  // Decode operator characters
  always_comb begin
    is_op   = 1'b1;
    op_code = pmsp_pkg::OP_SET;
    unique case (beat_i.character)
      pmsp_pkg::CH_EQ:    op_code = pmsp_pkg::OP_SET;
      pmsp_pkg::CH_PLUS:  op_code = pmsp_pkg::OP_ADD;
      pmsp_pkg::CH_MINUS: op_code = pmsp_pkg::OP_SUB;
      default:            is_op = 1'b0;
    endcase
  end

  // Start of string and octal digits
  always_comb begin
    a_st   = state_i;
    do_sym = 1'b0;
    case (state_i.phase)
      pmsp_pkg::PH_OCTAL: begin
        if (is_digit) begin
          a_st.working_mode = {state_i.working_mode[8:0], digit};
        end else begin
          a_st.phase = pmsp_pkg::PH_ERR_OCT;
        end
      end
      pmsp_pkg::PH_WHO, pmsp_pkg::PH_PERM: begin
        do_sym = 1'b1;
      end
      pmsp_pkg::PH_ERR_OCT, pmsp_pkg::PH_ERR_SYM: begin
        a_st = state_i;
      end
      default: begin
        a_st.who_mask   = '0;
        a_st.perm_mask  = '0;
        a_st.pending_op = pmsp_pkg::OP_SET;
        if (is_digit) begin
          a_st.working_mode = {9'd0, digit};
          a_st.phase        = pmsp_pkg::PH_OCTAL;
        end else begin
          a_st.working_mode = beat_i.base_mode;
          a_st.phase        = pmsp_pkg::PH_WHO;
          do_sym            = 1'b1;
        end
      end
    endcase
  end

  // Symbolic clause handling
  always_comb begin
    b_st = a_st;
    if (do_sym) begin
      if (a_st.phase == pmsp_pkg::PH_WHO) begin
        case (beat_i.character)
          pmsp_pkg::CH_U: b_st.who_mask = a_st.who_mask | pmsp_pkg::OWN_BITS;
          pmsp_pkg::CH_G: b_st.who_mask = a_st.who_mask | pmsp_pkg::GRP_BITS;
          pmsp_pkg::CH_O: b_st.who_mask = a_st.who_mask | pmsp_pkg::OTH_BITS;
          pmsp_pkg::CH_A: b_st.who_mask = a_st.who_mask | pmsp_pkg::ALL_BITS;
          default: begin
            // no who letter given: fall back to the umask default
            if (a_st.who_mask == '0) begin
              b_st.who_mask = pmsp_pkg::ALL_BITS & ~creation_mask_i;
            end
            if (is_op) begin
              b_st.pending_op = op_code;
              b_st.perm_mask  = '0;
              b_st.phase      = pmsp_pkg::PH_PERM;
            end else begin
              b_st.phase = pmsp_pkg::PH_ERR_SYM;
            end
          end
        endcase
      end else begin
        case (beat_i.character)
          pmsp_pkg::CH_R: b_st.perm_mask = a_st.perm_mask | pmsp_pkg::RD_BITS;
          pmsp_pkg::CH_W: b_st.perm_mask = a_st.perm_mask | pmsp_pkg::WR_BITS;
          pmsp_pkg::CH_X: b_st.perm_mask = a_st.perm_mask | pmsp_pkg::EX_BITS;
          pmsp_pkg::CH_S: b_st.perm_mask = a_st.perm_mask | pmsp_pkg::SID_BITS;
          pmsp_pkg::CH_T: b_st.perm_mask = a_st.perm_mask | pmsp_pkg::STICKY;
          pmsp_pkg::CH_U: begin
            b_st.perm_mask = a_st.perm_mask | spread(a_st.working_mode[8:6]) |
                             (a_st.working_mode[11] ? pmsp_pkg::SID_BITS : 12'd0) |
                             (a_st.working_mode[9] ? pmsp_pkg::STICKY : 12'd0);
          end
          pmsp_pkg::CH_G: b_st.perm_mask = a_st.perm_mask | spread(a_st.working_mode[5:3]);
          pmsp_pkg::CH_O: b_st.perm_mask = a_st.perm_mask | spread(a_st.working_mode[2:0]);
          default: begin
            // close the group, then chain, start a new clause or fail
            b_st.working_mode = apply_group(a_st.working_mode, a_st.who_mask,
                                            a_st.perm_mask, a_st.pending_op);
            if (is_op) begin
              b_st.pending_op = op_code;
              b_st.perm_mask  = '0;
            end else if (beat_i.character == pmsp_pkg::CH_COMMA) begin
              b_st.who_mask = '0;
              b_st.phase    = pmsp_pkg::PH_WHO;
            end else begin
              b_st.phase = pmsp_pkg::PH_ERR_SYM;
            end
          end
        endcase
      end
    end
  end

  // Finish the string on the last character
  always_comb begin
    res_mode   = '0;
    res_status = pmsp_pkg::ST_OK;
    case (b_st.phase)
      pmsp_pkg::PH_OCTAL: res_mode = b_st.working_mode;
      pmsp_pkg::PH_PERM: begin
        res_mode = apply_group(b_st.working_mode, b_st.who_mask,
                               b_st.perm_mask, b_st.pending_op);
      end
      pmsp_pkg::PH_ERR_OCT: res_status = pmsp_pkg::ST_BAD_OCT;
      default:              res_status = pmsp_pkg::ST_BAD_SYM;
    endcase
    ok   = (res_status == pmsp_pkg::ST_OK);
    warn = ok && !b_st.warning_given && !superuser_i && res_mode[9];

    state_o                 = b_st;
    push_o                  = beat_i.last;
    result_o.new_mode       = res_mode;
    result_o.status         = res_status;
    result_o.sticky_warning = warn;
    if (beat_i.last) begin
      state_o.phase         = pmsp_pkg::PH_START;
      state_o.who_mask      = '0;
      state_o.perm_mask     = '0;
      state_o.pending_op    = pmsp_pkg::OP_SET;
      state_o.working_mode  = '0;
      state_o.warning_given = b_st.warning_given | warn;
    end
  end

endmodule

### rtl/pmsp_out_buf.sv
// ----------------------------------------------------------------------------
// pmsp_out_buf
// Two-entry result buffer that parts the input side from output stalls.
// ----------------------------------------------------------------------------
module pmsp_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pmsp_pkg::out_t data_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pmsp_pkg::out_t out_data_o
);

  pmsp_pkg::out_t buf_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign out_data_o  = buf_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the result beat
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/permission_mode_string_parser.sv
// ----------------------------------------------------------------------------
// permission_mode_string_parser
// Reads a chmod-style mode string one character per beat and returns the
// new 12-bit mode, a status and a one-time sticky-bit warning.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o | in_data_i  (character, base_mode, last)
//  out     | output    | out_valid_o/out_stall_i | out_data_o (new_mode, status, warning)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One character is taken per cycle while the input is not stalled; the parser state updates in that cycle.
//  A last character puts its result in the output buffer, visible in the next cycle.
//  The two-entry output buffer stalls the input only when it is full.
//  Reset clears the parse state, the warning flag and loads the default umask.
// ----------------------------------------------------------------------------
module permission_mode_string_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  pmsp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pmsp_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [11:0]    cfg_data_i
);

  pmsp_pkg::state_t state_q, state_d;
  pmsp_pkg::out_t   result;
  logic             push_req;
  logic             buf_full;
  logic             in_acc;
  logic [11:0]      cmask_q;
  logic             super_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = buf_full;
  assign in_acc      = in_valid_i && !in_stall_o;

  pmsp_step u_step (
    .state_i         (state_q),
    .beat_i          (in_data_i),
    .creation_mask_i (cmask_q),
    .superuser_i     (super_q),
    .state_o         (state_d),
    .push_o          (push_req),
    .result_o        (result)
  );

  pmsp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc && push_req),
    .data_i      (result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Hold parse state, advance on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: pmsp_pkg::PH_START, who_mask: '0, pending_op: pmsp_pkg::OP_SET,
                   perm_mask: '0, working_mode: '0, warning_given: 1'b0};
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmask_q <= pmsp_pkg::CMASK_RST;
      super_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pmsp_pkg::CFG_CREATION_MASK: cmask_q <= cfg_data_i;
        pmsp_pkg::CFG_SUPERUSER:     super_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.last) |=> out_valid_o)
    else $error("last beat produced no result");

  a_warning_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.warning_given |=> state_q.warning_given)
    else $error("warning flag cleared without reset");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != pmsp_pkg::ST_OK) |->
      (out_data_o.new_mode == 12'd0 && !out_data_o.sticky_warning))
    else $error("error result carries mode or warning");

  a_warn_has_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.sticky_warning) |-> out_data_o.new_mode[9])
    else $error("warning without sticky bit");
`endif

endmodule
